// ===== design/pmc_pkg.sv =====
// Path-MTU cache package: sizes, request and scan-token types.
// Used by pmc_cell and path_mtu_cache; depends on nothing.
package pmc_pkg;

    localparam int NUM_ENTRIES = 128;
    localparam int IFACE_BITS  = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int ID_W        = (IFACE_BITS < 16) ? IFACE_BITS : 16;

    localparam logic [31:0] MAX_AGE_RESET = 32'd600000;
    localparam logic [1:0]  VER_V4        = 2'd0;
    localparam logic [1:0]  VER_V6        = 2'd1;

    typedef logic [IDX_W-1:0] idx_t;

    // Request as held for the whole scan, broadcast to all cells
    typedef struct packed {
        logic            note;
        logic [ID_W-1:0] id;
        logic [31:0]     epoch;
        logic            v6;
        logic [63:0]     ahi;
        logic [63:0]     alo;
        logic [15:0]     mtu;
        logic [31:0]     now;
    } req_t;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic        active;
        logic        done;
        logic        free_vld;
        idx_t        free_idx;
        logic        old_vld;
        idx_t        old_idx;
        logic [31:0] old_age;
        logic [15:0] res_mtu;
    } scan_t;

    // Fill or eviction write, broadcast at the end of a scan
    typedef struct packed {
        logic en;
        idx_t idx;
    } fill_t;

endpackage

// ===== design/pmc_req_if.sv =====
// Request channel interface of the path-MTU cache.
// Depends on nothing.
interface pmc_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] iface_id;
    logic [31:0] iface_epoch;
    logic [1:0]  ip_version;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] new_mtu;
    logic [31:0] now_ms;

    modport source (output valid, mode, iface_id, iface_epoch, ip_version, addr_hi,
                    addr_lo, new_mtu, now_ms, input ready);
    modport sink (input valid, mode, iface_id, iface_epoch, ip_version, addr_hi,
                  addr_lo, new_mtu, now_ms, output ready);
endinterface

// ===== design/pmc_rsp_if.sv =====
// Response channel interface of the path-MTU cache.
// Depends on nothing.
interface pmc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] mtu_out;

    modport source (output valid, mtu_out, input ready);
    modport sink (input valid, mtu_out, output ready);
endinterface

// ===== design/pmc_cell.sv =====
// One table slot of the path-MTU cache with its stage of the scan chain.
// Depends on pmc_pkg.
module pmc_cell
    import pmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  idx_t        cell_idx,
    input  logic [31:0] max_age,
    input  req_t        req,
    input  scan_t       scan_in,
    input  fill_t       fill,
    output scan_t       scan_out
);

    logic            valid_reg, valid_next;
    logic [63:0]     ahi_reg, ahi_next;
    logic [63:0]     alo_reg, alo_next;
    logic            v6_reg, v6_next;
    logic [ID_W-1:0] iface_reg, iface_next;
    logic [31:0]     epoch_reg, epoch_next;
    logic [31:0]     time_reg, time_next;
    logic [15:0]     mtu_reg, mtu_next;
    scan_t           scan_reg, scan_next;

    logic [31:0] age;
    logic        expire;
    logic        hit;
    logic        act;
    logic [15:0] low_mtu;

    // Slot checks against the broadcast request
    assign age     = req.now - time_reg;
    assign expire  = (age >= max_age) || ((iface_reg == req.id) && (epoch_reg != req.epoch));
    assign hit     = (iface_reg == req.id) && (v6_reg == req.v6) &&
                     (ahi_reg == req.ahi) && (alo_reg == req.alo);
    assign act     = scan_in.active && !scan_in.done;
    assign low_mtu = (req.mtu < mtu_reg) ? req.mtu : mtu_reg;

    // Slot update and token hand-on
    always_comb
    begin
        valid_next = valid_reg;
        ahi_next   = ahi_reg;
        alo_next   = alo_reg;
        v6_next    = v6_reg;
        iface_next = iface_reg;
        epoch_next = epoch_reg;
        time_next  = time_reg;
        mtu_next   = mtu_reg;
        scan_next  = scan_in;
        if (act)
        begin
            if (!valid_reg)
            begin
                if (!scan_in.free_vld)
                begin
                    scan_next.free_vld = 1'b1;
                    scan_next.free_idx = cell_idx;
                end
            end
            else if (expire)
            begin
                valid_next = 1'b0;
                if (!scan_in.free_vld)
                begin
                    scan_next.free_vld = 1'b1;
                    scan_next.free_idx = cell_idx;
                end
            end
            else if (hit)
            begin
                scan_next.done = 1'b1;
                if (req.note)
                begin
                    mtu_next          = low_mtu;
                    time_next         = req.now;
                    scan_next.res_mtu = low_mtu;
                end
                else
                begin
                    scan_next.res_mtu = mtu_reg;
                end
            end
            else if (req.note && (!scan_in.old_vld || (age > scan_in.old_age)))
            begin
                scan_next.old_vld = 1'b1;
                scan_next.old_idx = cell_idx;
                scan_next.old_age = age;
            end
        end
        // end-of-scan fill never coincides with this cell's active token
        if (fill.en && (fill.idx == cell_idx))
        begin
            valid_next = 1'b1;
            ahi_next   = req.ahi;
            alo_next   = req.alo;
            v6_next    = req.v6;
            iface_next = req.id;
            epoch_next = req.epoch;
            time_next  = req.now;
            mtu_next   = req.mtu;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            scan_reg  <= scan_next;
        end
    end

    // Slot payload
    always_ff @(posedge clk)
    begin
        ahi_reg   <= ahi_next;
        alo_reg   <= alo_next;
        v6_reg    <= v6_next;
        iface_reg <= iface_next;
        epoch_reg <= epoch_next;
        time_reg  <= time_next;
        mtu_reg   <= mtu_next;
    end

    assign scan_out = scan_reg;

endmodule

// ===== design/path_mtu_cache.sv =====
// Path-MTU cache top level: request sequencing, chain of table cells, response register.
// Depends on pmc_pkg, pmc_req_if, pmc_rsp_if and pmc_cell.
//
// A request is taken when req.ready is high; one transaction is handled at a time. A valid
// request sends a scan token down a chain of NUM_ENTRIES cells, one cell per clock; its
// response is loaded into the response register from the last cell's token, and the
// next request can be taken in that same cycle; the chain length sets the scan time. An
// invalid request is answered with 0 without a scan, once no response is held on rsp.
// A request waits before its scan while a previous response is still held on rsp, and
// req.ready goes high again as the response is loaded. max_age_ms is written through
// cfg_we/cfg_wdata while the block is idle; the user is bound to this, the block does not enforce it.
module path_mtu_cache
    import pmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    pmc_req_if.sink     req,
    pmc_rsp_if.source   rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] max_age_reg;
    req_t        rq_reg;
    logic        bad_reg;
    logic        out_vld_reg, out_vld_next;
    logic [15:0] out_mtu_reg, out_mtu_next;

    scan_t       tok [NUM_ENTRIES+1];
    fill_t       fill;
    logic        accept;
    logic        out_free;
    logic        launch;
    logic        finish;
    logic [ID_W-1:0] in_id;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_vld_reg || rsp.ready;
    assign launch   = (state_reg == ST_WAIT) && out_free && !bad_reg;
    assign finish   = tok[NUM_ENTRIES].active;
    assign in_id    = req.iface_id[ID_W-1:0];

    // Token entering the chain
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = launch;
    end

    // Cell chain
    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        pmc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (idx_t'(i)),
            .max_age  (max_age_reg),
            .req      (rq_reg),
            .scan_in  (tok[i]),
            .fill     (fill),
            .scan_out (tok[i+1])
        );
    end

    // Fill the first free slot, else evict the oldest, on a note that missed
    always_comb
    begin
        fill.en  = finish && !tok[NUM_ENTRIES].done && rq_reg.note &&
                   (tok[NUM_ENTRIES].free_vld || tok[NUM_ENTRIES].old_vld);
        fill.idx = tok[NUM_ENTRIES].free_vld ? tok[NUM_ENTRIES].free_idx
                                             : tok[NUM_ENTRIES].old_idx;
    end

    // Sequencer and response register
    always_comb
    begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg;
        out_mtu_next = out_mtu_reg;
        if (out_vld_reg && rsp.ready)
            out_vld_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    if (bad_reg)
                    begin
                        out_vld_next = 1'b1;
                        out_mtu_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    out_vld_next = 1'b1;
                    if (tok[NUM_ENTRIES].done)
                        out_mtu_next = tok[NUM_ENTRIES].res_mtu;
                    else if (fill.en)
                        out_mtu_next = rq_reg.mtu;
                    else
                        out_mtu_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            max_age_reg <= MAX_AGE_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
                max_age_reg <= cfg_wdata;
        end
    end

    // Request capture; IPv4 keeps only the top 32 address bits
    always_ff @(posedge clk)
    begin
        out_mtu_reg <= out_mtu_next;
        if (accept)
        begin
            rq_reg.note  <= req.mode;
            rq_reg.id    <= in_id;
            rq_reg.epoch <= req.iface_epoch;
            rq_reg.v6    <= (req.ip_version == VER_V6);
            rq_reg.ahi   <= (req.ip_version == VER_V6) ? req.addr_hi
                                                       : {req.addr_hi[63:32], 32'd0};
            rq_reg.alo   <= (req.ip_version == VER_V6) ? req.addr_lo : 64'd0;
            rq_reg.mtu   <= req.new_mtu;
            rq_reg.now   <= req.now_ms;
            bad_reg      <= (in_id == '0) || (req.iface_epoch == 32'd0) ||
                            !((req.ip_version == VER_V4) || (req.ip_version == VER_V6)) ||
                            (req.mode && (req.new_mtu == 16'd0));
        end
    end

    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_vld_reg;
    assign rsp.mtu_out = out_mtu_reg;

endmodule

// ===== design/pmc_checker.sv =====
// Port-level checks of the path-MTU cache, bound to the top level.
// Depends on path_mtu_cache's ports only.
module pmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] mtu_out
);

    // One transaction at a time: no request taken straight after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while busy");

    // A waiting response holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(mtu_out)))
        else $error("response dropped or changed while stalled");

    // A new response only comes out of a request in progress
    a_rsp_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response without a request in progress");

endmodule

bind path_mtu_cache pmc_checker u_pmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .mtu_out   (rsp.mtu_out)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the path-MTU cache: directed and random requests with idling.
// A scoreboard class predicts each response; depends on pmc_pkg, pmc_req_if, pmc_rsp_if and path_mtu_cache.
module tb
    import pmc_pkg::*;
();

    typedef struct {
        logic        mode;
        logic [15:0] iface_id;
        logic [31:0] iface_epoch;
        logic [1:0]  ip_version;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] new_mtu;
        logic [31:0] now_ms;
    } mtu_req_t;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_NOTE   = 1'b1;

    // Scoreboard: own copy of the table, predicts mtu_out per request
    class mtu_scoreboard;
        logic [31:0] max_age;
        bit          valid_q [NUM_ENTRIES];
        logic [63:0] ahi_q [NUM_ENTRIES];
        logic [63:0] alo_q [NUM_ENTRIES];
        bit          v6_q [NUM_ENTRIES];
        logic [15:0] id_q [NUM_ENTRIES];
        logic [31:0] epoch_q [NUM_ENTRIES];
        logic [31:0] stamp_q [NUM_ENTRIES];
        logic [15:0] mtu_q [NUM_ENTRIES];
        logic [15:0] expected_mtu [$];
        int          errors;

        function new();
            max_age = MAX_AGE_RESET;
            errors  = 0;
            foreach (valid_q[i]) valid_q[i] = 0;
        endfunction

        function logic [15:0] lookup_or_note(mtu_req_t r);
            logic [63:0] ahi;
            logic [63:0] alo;
            logic [31:0] age;
            logic [31:0] worst_age;
            bit          v6;
            int          first_free;
            int          oldest;
            int          slot;
            ahi = r.addr_hi;
            alo = r.addr_lo;
            first_free = -1;
            oldest = -1;
            worst_age = 0;
            if (r.iface_id == 0 || r.iface_epoch == 0 || r.ip_version > VER_V6 ||
                (r.mode == MODE_NOTE && r.new_mtu == 0))
                return 16'd0;
            v6 = (r.ip_version == VER_V6);
            if (!v6)
            begin
                ahi[31:0] = 32'd0;
                alo = 64'd0;
            end
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (!valid_q[i])
                begin
                    if (first_free < 0) first_free = i;
                    continue;
                end
                age = r.now_ms - stamp_q[i];
                if (age >= max_age || (id_q[i] == r.iface_id && epoch_q[i] != r.iface_epoch))
                begin
                    valid_q[i] = 0;
                    if (first_free < 0) first_free = i;
                    continue;
                end
                if (id_q[i] == r.iface_id && v6_q[i] == v6 && ahi_q[i] == ahi &&
                    alo_q[i] == alo)
                begin
                    if (r.mode == MODE_NOTE)
                    begin
                        if (r.new_mtu < mtu_q[i]) mtu_q[i] = r.new_mtu;
                        stamp_q[i] = r.now_ms;
                    end
                    return mtu_q[i];
                end
                if (r.mode == MODE_NOTE && (oldest < 0 || age > worst_age))
                begin
                    oldest = i;
                    worst_age = age;
                end
            end
            if (r.mode != MODE_NOTE)
                return 16'd0;
            slot = (first_free >= 0) ? first_free : oldest;
            if (slot < 0)
                return 16'd0;
            valid_q[slot] = 1;
            v6_q[slot]    = v6;
            id_q[slot]    = r.iface_id;
            epoch_q[slot] = r.iface_epoch;
            mtu_q[slot]   = r.new_mtu;
            stamp_q[slot] = r.now_ms;
            ahi_q[slot]   = ahi;
            alo_q[slot]   = alo;
            return r.new_mtu;
        endfunction

        function void note_request(mtu_req_t r);
            expected_mtu.push_back(lookup_or_note(r));
        endfunction

        function void check_response(logic [15:0] mtu);
            logic [15:0] exp_mtu;
            if (expected_mtu.size() == 0)
            begin
                $error("unexpected response: mtu_out %0d", mtu);
                errors++;
                return;
            end
            exp_mtu = expected_mtu.pop_front();
            if (mtu !== exp_mtu)
            begin
                $error("mtu_out: expected %0d, actual %0d", exp_mtu, mtu);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    pmc_req_if req ();
    pmc_rsp_if rsp ();

    path_mtu_cache DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    mtu_scoreboard sb = new();
    bit            calm;         // no idling in the closing part
    int            sent;
    int            quiet_cycles = 0;
    logic [31:0]   now;

    // Key pool for random traffic
    logic [15:0] pool_id [200];
    logic [1:0]  pool_ver [200];
    logic [63:0] pool_ahi [200];
    logic [63:0] pool_alo [200];
    logic [31:0] epoch_of [8];

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Send one transaction and wait for its acceptance
    task automatic send_req(mtu_req_t r);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= r.mode;
        req.iface_id    <= r.iface_id;
        req.iface_epoch <= r.iface_epoch;
        req.ip_version  <= r.ip_version;
        req.addr_hi     <= r.addr_hi;
        req.addr_lo     <= r.addr_lo;
        req.new_mtu     <= r.new_mtu;
        req.now_ms      <= r.now_ms;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sb.note_request(r);
        sent++;
    endtask

    // Wait until every response is in, then let the block settle
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_mtu.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_age(logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.max_age = v;
        @(posedge clk);
    endtask

    function automatic mtu_req_t make_req(logic m, logic [15:0] id, logic [31:0] ep,
                                          logic [1:0] ver, logic [63:0] hi, logic [63:0] lo,
                                          logic [15:0] mtu, logic [31:0] t);
        mtu_req_t r;
        r.mode = m; r.iface_id = id; r.iface_epoch = ep; r.ip_version = ver;
        r.addr_hi = hi; r.addr_lo = lo; r.new_mtu = mtu; r.now_ms = t;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly well-formed traffic over a key pool, some raw noise
    function automatic mtu_req_t random_req(int span, int step);
        int k;
        logic [31:0] ep;
        now = now + $urandom_range(0, step);
        if ($urandom_range(0, 9) == 0)
            return make_req(1'($urandom()), 16'($urandom()),
                            $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom()),
                            2'($urandom()), rand64(), rand64(),
                            $urandom_range(0, 5) == 0 ? 16'd0 : 16'($urandom()),
                            32'($urandom()));
        k = $urandom_range(0, span - 1);
        if ($urandom_range(0, 49) == 0)
            epoch_of[pool_id[k][2:0]] = 32'($urandom_range(1, 3));
        ep = epoch_of[pool_id[k][2:0]];
        return make_req(1'($urandom()), pool_id[k], ep, pool_ver[k], pool_ahi[k],
                        $urandom_range(0, 3) == 0 ? rand64() : pool_alo[k],
                        16'($urandom_range(576, 9000)), now);
    endfunction

    // Response side: random stalls plus one long hold-off
    initial
    begin
        int stall;
        bit held;
        held = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent >= 400)
            begin
                held = 1;
                rsp.ready <= 1'b0;
                repeat (700) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 6);
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Response checker
    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.mtu_out);

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        logic [31:0] ages [5];
        calm = 0;
        sent = 0;
        now = 32'd1000;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req.valid <= 1'b0;
        req.mode <= MODE_LOOKUP;
        req.iface_id <= '0;
        req.iface_epoch <= '0;
        req.ip_version <= VER_V4;
        req.addr_hi <= '0;
        req.addr_lo <= '0;
        req.new_mtu <= '0;
        req.now_ms <= '0;
        for (int i = 0; i < 200; i++)
        begin
            pool_id[i]  = 16'($urandom_range(1, 6));
            pool_ver[i] = 2'($urandom_range(0, 1));
            pool_ahi[i] = rand64();
            pool_alo[i] = rand64();
        end
        foreach (epoch_of[i]) epoch_of[i] = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: invalid requests, IPv4 masking, min rule, epoch change, expiry, wrap
        send_req(make_req(MODE_NOTE, 16'd0, 32'd1, VER_V4, '1, '1, 16'd1500, now));
        send_req(make_req(MODE_NOTE, 16'd1, 32'd0, VER_V4, '1, '1, 16'd1500, now));
        send_req(make_req(MODE_NOTE, 16'd1, 32'd1, 2'd2, '1, '1, 16'd1500, now));
        send_req(make_req(MODE_NOTE, 16'd1, 32'd1, 2'd3, '1, '1, 16'd1500, now));
        send_req(make_req(MODE_NOTE, 16'd1, 32'd1, VER_V4, '1, '1, 16'd0, now));
        send_req(make_req(MODE_LOOKUP, 16'd1, 32'd1, VER_V4, '1, '1, 16'd0, now));
        send_req(make_req(MODE_NOTE, 16'hFFFF, '1, VER_V4, 64'hC0A8_0001_1234_5678, '1,
                          16'hFFFF, now));
        send_req(make_req(MODE_LOOKUP, 16'hFFFF, '1, VER_V4, 64'hC0A8_0001_0000_0000, '0,
                          16'd0, now));
        send_req(make_req(MODE_NOTE, 16'hFFFF, '1, VER_V6, '1, '1, 16'd9000, now));
        send_req(make_req(MODE_NOTE, 16'hFFFF, '1, VER_V6, '1, '1, 16'd1280, now + 1));
        send_req(make_req(MODE_NOTE, 16'hFFFF, '1, VER_V6, '1, '1, 16'd1500, now + 2));
        send_req(make_req(MODE_LOOKUP, 16'hFFFF, '1, VER_V6, '1, '0, 16'd0, now + 2));
        send_req(make_req(MODE_LOOKUP, 16'hFFFF, '1, VER_V6, '1, '1, 16'd0, now + 3));
        send_req(make_req(MODE_NOTE, 16'd1, 32'd7, VER_V6, '0, '0, 16'd1, now + 3));
        send_req(make_req(MODE_LOOKUP, 16'hFFFF, 32'd5, VER_V6, '1, '1, 16'd0, now + 4));
        send_req(make_req(MODE_LOOKUP, 16'd1, 32'd7, VER_V6, '0, '0, 16'd0,
                          now + 32'd600000));
        send_req(make_req(MODE_NOTE, 16'd2, 32'd1, VER_V4, '0, '0, 16'd1400, 32'hFFFF_FFF0));
        send_req(make_req(MODE_LOOKUP, 16'd2, 32'd1, VER_V4, '0, '0, 16'd0, 32'd20));
        drain();

        // Random phases over several expiry settings
        ages[0] = 32'd1;
        ages[1] = 32'hFFFF_FFFF;
        ages[2] = 32'd40;
        ages[3] = MAX_AGE_RESET;
        ages[4] = 32'd2000;
        for (int p = 0; p < 5; p++)
        begin
            write_max_age(ages[p]);
            for (int n = 0; n < 220; n++)
            begin
                if (p == 4 && n >= 140) calm = 1;
                send_req(random_req(p == 1 ? 200 : 40, p == 0 ? 1 : 30));
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_mtu.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
